// ===== design/stprd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the stepper ramp delay generator: types, field widths and codes.
// Used by stprd_div and stepper_ramp_delay_generator_core; no dependencies.
package stprd_pkg;

  localparam int TSTEP_W = 32;
  localparam int DELAY_W = 24;
  localparam int CUR_W   = 32;
  localparam int POS_W   = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_DIV   = 6'b000100,
    S_APPLY = 6'b001000,
    S_RES   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    M_HOLD      = 2'd0,
    M_DOWN_STOP = 2'd1,
    M_DOWN_SLEW = 2'd2,
    M_UP        = 2'd3
  } mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== design/stprd_div.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on stprd_pkg.
module stprd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stprd_pkg::CUR_W-1:0] numer,
  input  logic [stprd_pkg::CUR_W-1:0] denom,
  output logic [stprd_pkg::CUR_W-1:0] quot,
  output stprd_pkg::div_sts_t         sts
);

  localparam int W   = stprd_pkg::CUR_W;
  localparam int CNW = $clog2(W);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [W-1:0]   den_r, den_nxt;
  logic [W+1:0]   diff;

  assign diff = {1'b0, rem_r, quo_r[W-1]} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = numer;
      den_nxt  = denom;
    end else if (busy_r) begin
      if (diff[W+1]) begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + CNW'(1);
      if (cnt_r == CNW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quot      = quo_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;

endmodule

// ===== design/stepper_ramp_delay_generator_core.sv =====
`timescale 1ns / 1ps
// Stepper step-delay generator, linear speed ramp, top level.
// Depends on stprd_pkg and stprd_div.
//
// Usage:
//   Each input item requests the next step and carries the stop step and
//   the cruise delay. One result item per request: step_delay (16.8 ticks,
//   0 once stopped on target) and position (steps made so far).
//   cfg_wr_en/cfg_wr_data write first_delay; write only while idle.
// Timing:
//   in_tready is high only while idle; one item is handled at a time.
//   A ramp step (acceleration or deceleration) runs one rounded division
//   on the shared 32-bit bit-serial divider; stop, first-step and hold
//   items skip the divider. The divider loop sets the rate of ramp items.
// Reset (rst_n low, synchronous): step count, ramp index, current and slew
//   delays and first_delay clear; no result pending.
// Stall: the result sits in the output register until out_tready; a new
//   item is taken meanwhile, and its result waits until the register frees.
module stepper_ramp_delay_generator_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [stprd_pkg::DELAY_W-1:0]     cfg_wr_data,   // first_delay
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] stop_step, [55:32] cruise_delay
  input  logic [stprd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] step_delay, [63:32] position
  output logic [stprd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW = COUNT_WIDTH;
  localparam int DW = stprd_pkg::DELAY_W;
  localparam int XW = stprd_pkg::CUR_W;

  stprd_pkg::state_t state_r, state_nxt;
  stprd_pkg::mode_t  mode_r, mode_nxt;

  logic [DW-1:0] first_delay_r;
  logic [CW-1:0] step_count_r, step_count_nxt;
  logic [CW-1:0] ramp_r, ramp_nxt;
  logic [XW-1:0] cur_r, cur_nxt;
  logic [DW-1:0] slew_r, slew_nxt;
  logic [CW-1:0] tstep_r;
  logic [DW-1:0] tdelay_r;
  logic [XW-1:0] res_r, res_nxt;
  logic          out_valid_r;
  logic [XW-1:0] out_delay_r;
  logic [CW-1:0] out_pos_r;

  logic          in_acc;
  logic          out_free;
  logic [DW-1:0] slew_eff;
  logic [CW-1:0] proj;
  logic [CW-1:0] ramp_dn;
  logic [XW-1:0] q_up, q_dn, q_sel, numer;
  logic          div_start;
  logic [XW-1:0] div_quot;
  stprd_pkg::div_sts_t div_sts;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == stprd_pkg::S_IDLE);

  assign slew_eff = (slew_r != '0 && slew_r != tdelay_r) ? '0 : slew_r;
  assign proj     = step_count_r + ramp_r;
  assign ramp_dn  = ramp_r - CW'(1);
  assign q_up     = (XW'(ramp_r) << 2) + XW'(1);
  assign q_dn     = (XW'(ramp_dn) << 2) - XW'(1);
  assign q_sel    = (mode_nxt == stprd_pkg::M_UP) ? q_up : q_dn;
  assign numer    = (cur_r << 1) + (q_sel >> 1);

  stprd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (q_sel),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    step_count_nxt = step_count_r;
    ramp_nxt       = ramp_r;
    cur_nxt        = cur_r;
    slew_nxt       = slew_r;
    res_nxt        = res_r;
    div_start      = 1'b0;
    unique case (state_r)
      stprd_pkg::S_IDLE: begin
        if (in_acc) state_nxt = stprd_pkg::S_EVAL;
      end
      stprd_pkg::S_EVAL: begin
        if (step_count_r >= tstep_r && ramp_r <= CW'(1)) begin
          ramp_nxt  = '0;
          res_nxt   = '0;
          state_nxt = stprd_pkg::S_OUT;
        end else begin
          slew_nxt       = slew_eff;
          step_count_nxt = step_count_r + CW'(1);
          if (ramp_r == '0) begin
            cur_nxt   = XW'(first_delay_r);
            ramp_nxt  = CW'(1);
            res_nxt   = XW'(first_delay_r);
            state_nxt = stprd_pkg::S_OUT;
          end else begin
            if (proj == tstep_r) begin
              mode_nxt = stprd_pkg::M_HOLD;
            end else if (proj > tstep_r) begin
              mode_nxt = stprd_pkg::M_DOWN_STOP;
            end else if (slew_eff == '0 && cur_r < XW'(tdelay_r)) begin
              mode_nxt = stprd_pkg::M_DOWN_SLEW;
            end else if (slew_eff == '0 && cur_r > XW'(tdelay_r)) begin
              mode_nxt = stprd_pkg::M_UP;
            end else begin
              mode_nxt = stprd_pkg::M_HOLD;
            end
            if (mode_nxt == stprd_pkg::M_HOLD) begin
              state_nxt = stprd_pkg::S_RES;
            end else begin
              ramp_nxt  = (mode_nxt == stprd_pkg::M_UP) ? ramp_r + CW'(1) : ramp_dn;
              div_start = 1'b1;
              state_nxt = stprd_pkg::S_DIV;
            end
          end
        end
      end
      stprd_pkg::S_DIV: begin
        if (div_sts.done) state_nxt = stprd_pkg::S_APPLY;
      end
      stprd_pkg::S_APPLY: begin
        cur_nxt   = (mode_r == stprd_pkg::M_UP) ? cur_r - div_quot : cur_r + div_quot;
        state_nxt = stprd_pkg::S_RES;
      end
      stprd_pkg::S_RES: begin
        case (mode_r)
          stprd_pkg::M_DOWN_STOP: slew_nxt = '0;
          stprd_pkg::M_DOWN_SLEW: if (cur_r >= XW'(tdelay_r)) slew_nxt = tdelay_r;
          stprd_pkg::M_UP:        if (cur_r <= XW'(tdelay_r)) slew_nxt = tdelay_r;
          default:                slew_nxt = slew_r;
        endcase
        res_nxt   = (slew_nxt != '0) ? XW'(slew_nxt) : cur_r;
        state_nxt = stprd_pkg::S_OUT;
      end
      stprd_pkg::S_OUT: begin
        if (out_free) state_nxt = stprd_pkg::S_IDLE;
      end
      default: state_nxt = stprd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= stprd_pkg::S_IDLE;
      mode_r        <= stprd_pkg::M_HOLD;
      first_delay_r <= '0;
      step_count_r  <= '0;
      ramp_r        <= '0;
      cur_r         <= '0;
      slew_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      step_count_r <= step_count_nxt;
      ramp_r       <= ramp_nxt;
      cur_r        <= cur_nxt;
      slew_r       <= slew_nxt;
      if (cfg_wr_en) first_delay_r <= cfg_wr_data;
      if (state_r == stprd_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    res_r <= res_nxt;
    if (in_acc) begin
      tstep_r  <= in_tdata[CW-1:0];
      tdelay_r <= in_tdata[stprd_pkg::TSTEP_W +: DW];
    end
    if (state_r == stprd_pkg::S_OUT && out_free) begin
      out_delay_r <= res_r;
      out_pos_r   <= step_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {stprd_pkg::POS_W'(out_pos_r), out_delay_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted twice without finishing");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == stprd_pkg::S_DIV)
    else $error("divider finished outside division state");

  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_sts.busy)
    else $error("divider busy while block idle");

endmodule
